### design/hashed_key_value_table_core_assert.svh
// ----------------------------------------------------------------------------
// Hashed key-value table assertion macros
// Shared property forms for the checker. Clock is clock, reset is reset.
// ----------------------------------------------------------------------------
`ifndef HASHED_KEY_VALUE_TABLE_CORE_ASSERT_SVH
`define HASHED_KEY_VALUE_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define HKVT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hkvt: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define HKVT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hkvt: next-cycle check failed");

`endif

### design/hkvt_pkg.sv
// ----------------------------------------------------------------------------
// hkvt_pkg
// Sizes, derived widths and op codes of the hashed key-value table.
// ----------------------------------------------------------------------------
package hkvt_pkg;

   // table geometry
   localparam int BUCKETS    = 64;
   localparam int WAYS       = 4;
   localparam int VALUE_BITS = 32;
   localparam int SLOTS      = BUCKETS * WAYS;

   // fixed field widths
   localparam int OP_BITS   = 3;
   localparam int KEY_BITS  = 32;
   localparam int IN_BITS   = 32;
   localparam int DATA_BITS = 32;

   // derived widths
   localparam int BKT_BITS  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // op codes
   localparam logic [OP_BITS-1:0] OP_ADD    = 3'd0;
   localparam logic [OP_BITS-1:0] OP_UPDATE = 3'd1;
   localparam logic [OP_BITS-1:0] OP_UPSERT = 3'd2;
   localparam logic [OP_BITS-1:0] OP_GET    = 3'd3;
   localparam logic [OP_BITS-1:0] OP_REMOVE = 3'd4;

endpackage

### design/hashed_key_value_table_core.sv
// ----------------------------------------------------------------------------
// hashed_key_value_table_core
// Key-value table, BUCKETS buckets of WAYS slots, probed one way at a time.
// ----------------------------------------------------------------------------
// One request beat in, one response beat out. The bucket is key mod BUCKETS,
// registered in the cycle after the request is taken. The ways of the bucket
// are then probed in order through one key compare, each way by a PROBE state
// (RAM read), then a CMP state (compare); the probe stops at a hit. The ACT
// state commits the write-back and loads the response register; it waits
// while the previous response is not yet taken. The next request can be
// taken once the sequencer is back in idle. Keys and values sit in RAMs
// with no reset; valid bits are flip-flops cleared by reset, so the table
// is usable right after reset. A finished response waits in its register
// and a new request can be taken meanwhile.
module hashed_key_value_table_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [hkvt_pkg::OP_BITS-1:0]    req_op,
   input  logic [hkvt_pkg::KEY_BITS-1:0]   req_key,
   input  logic [hkvt_pkg::IN_BITS-1:0]    req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_ok,
   output logic [hkvt_pkg::DATA_BITS-1:0]  rsp_data
);

   import hkvt_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MOD   = 3'd1;
   localparam logic [2:0] ST_PROBE = 3'd2;
   localparam logic [2:0] ST_CMP   = 3'd3;
   localparam logic [2:0] ST_ACT   = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [OP_BITS-1:0]    op_ff, op_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [SLOT_BITS-1:0]  base_ff, base_in;
   logic [WAY_BITS-1:0]   way_ff, way_in;
   logic                  hit_ff, hit_in;
   logic                  free_ff, free_in;
   logic [SLOT_BITS-1:0]  hit_addr_ff, hit_addr_in;
   logic [SLOT_BITS-1:0]  free_addr_ff, free_addr_in;
   logic [DATA_BITS-1:0]  data_ff, data_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_ok_ff, rsp_ok_in;
   logic [DATA_BITS-1:0]  rsp_data_ff, rsp_data_in;
   logic [SLOTS-1:0]      valid_ff;

   logic                  req_beat;
   logic                  out_free;
   logic                  commit;
   logic                  mod_done;
   logic [BKT_BITS-1:0]   mod_bucket;
   logic [SLOT_BITS-1:0]  probe_addr;
   logic [KEY_BITS-1:0]   key_rd;
   logic [VALUE_BITS-1:0] val_rd;
   logic                  slot_vld;
   logic                  key_match;

   logic                  act_ok;
   logic [DATA_BITS-1:0]  act_data;
   logic                  wr_key_en;
   logic                  wr_val_en;
   logic                  set_valid;
   logic                  clr_valid;
   logic [SLOT_BITS-1:0]  wr_addr;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_beat  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign commit    = (state_ff == ST_ACT) && out_free;

   // bucket index unit
   hkvt_mod u_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (req_beat),
      .key    (req_key),
      .done   (mod_done),
      .bucket (mod_bucket)
   );

   // slot storage
   assign probe_addr = base_ff + SLOT_BITS'(way_ff);

   hkvt_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_key_en),
      .wr_addr (wr_addr),
      .wr_data (key_ff),
      .rd_addr (probe_addr),
      .rd_data (key_rd)
   );

   hkvt_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS)) u_val_ram (
      .clock   (clock),
      .wr_en   (wr_val_en),
      .wr_addr (wr_addr),
      .wr_data (val_ff),
      .rd_addr (probe_addr),
      .rd_data (val_rd)
   );

   // shared way compare
   assign slot_vld  = valid_ff[probe_addr];
   assign key_match = slot_vld && (key_rd == key_ff);

   // op decision and write-back
   always_comb begin
      act_ok    = 1'b0;
      act_data  = '0;
      wr_key_en = 1'b0;
      wr_val_en = 1'b0;
      set_valid = 1'b0;
      clr_valid = 1'b0;
      wr_addr   = hit_addr_ff;
      case (op_ff)
         OP_ADD, OP_UPSERT: begin
            if (hit_ff) begin
               if (op_ff == OP_UPSERT) begin
                  wr_val_en = commit;
                  act_ok    = 1'b1;
               end
            end else if (free_ff) begin
               wr_addr   = free_addr_ff;
               wr_key_en = commit;
               wr_val_en = commit;
               set_valid = commit;
               act_ok    = 1'b1;
            end
         end
         OP_UPDATE: begin
            if (hit_ff) begin
               wr_val_en = commit;
               act_ok    = 1'b1;
            end
         end
         OP_GET: begin
            if (hit_ff) begin
               act_ok   = 1'b1;
               act_data = data_ff;
            end
         end
         OP_REMOVE: begin
            if (hit_ff) begin
               act_ok    = 1'b1;
               act_data  = data_ff;
               clr_valid = commit;
            end
         end
         default: begin
            act_ok = 1'b0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      base_in      = base_ff;
      way_in       = way_ff;
      hit_in       = hit_ff;
      free_in      = free_ff;
      hit_addr_in  = hit_addr_ff;
      free_addr_in = free_addr_ff;
      data_in      = data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               op_in    = req_op;
               key_in   = req_key;
               val_in   = VALUE_BITS'(req_value);
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               base_in  = SLOT_BITS'(mod_bucket) * SLOT_BITS'(WAYS);
               way_in   = '0;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (key_match) begin
               hit_in      = 1'b1;
               hit_addr_in = probe_addr;
               data_in     = DATA_BITS'(val_rd);
            end
            if (!slot_vld && !free_ff) begin
               free_in      = 1'b1;
               free_addr_in = probe_addr;
            end
            if (key_match || (way_ff == WAY_BITS'(WAYS - 1))) begin
               state_in = ST_ACT;
            end else begin
               way_in   = way_ff + 1'b1;
               state_in = ST_PROBE;
            end
         end
         ST_ACT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = act_ok;
               rsp_data_in  = act_data;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (set_valid) begin
            valid_ff[wr_addr] <= 1'b1;
         end else if (clr_valid) begin
            valid_ff[wr_addr] <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      val_ff       <= val_in;
      base_ff      <= base_in;
      way_ff       <= way_in;
      hit_ff       <= hit_in;
      free_ff      <= free_in;
      hit_addr_ff  <= hit_addr_in;
      free_addr_ff <= free_addr_in;
      data_ff      <= data_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok    = rsp_ok_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### design/hkvt_ram.sv
// ----------------------------------------------------------------------------
// hkvt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module hkvt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/hkvt_mod.sv
// ----------------------------------------------------------------------------
// hkvt_mod
// Bucket index unit: key modulo BUCKETS, registered on start and valid in the cycle after it.
// ----------------------------------------------------------------------------
module hkvt_mod (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [hkvt_pkg::KEY_BITS-1:0]  key,
   output logic                           done,
   output logic [hkvt_pkg::BKT_BITS-1:0]  bucket
);

   import hkvt_pkg::*;

   logic                  done_ff, done_in;
   logic [BKT_BITS-1:0]   bucket_ff, bucket_in;

   // bucket count is a power of two, so the remainder is the low key bits
   always_comb begin
      done_in   = start;
      bucket_in = bucket_ff;
      if (start) begin
         bucket_in = BKT_BITS'(key % KEY_BITS'(BUCKETS));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      bucket_ff <= bucket_in;
   end

   assign done   = done_ff;
   assign bucket = bucket_ff;

endmodule

### design/hkvt_checker.sv
// ----------------------------------------------------------------------------
// hkvt_checker
// Port-level checks of the hashed key-value table, bound to the top level.
// ----------------------------------------------------------------------------
`include "hashed_key_value_table_core_assert.svh"

module hkvt_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [hkvt_pkg::OP_BITS-1:0]    req_op,
   input  logic [hkvt_pkg::KEY_BITS-1:0]   req_key,
   input  logic [hkvt_pkg::IN_BITS-1:0]    req_value,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic                            rsp_ok,
   input  logic [hkvt_pkg::DATA_BITS-1:0]  rsp_data
);

   import hkvt_pkg::*;

   logic req_beat;
   logic rsp_stall;

   assign req_beat  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;

   // a stalled response beat holds
   `HKVT_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_ok) && $stable(rsp_data))

   // a taken request keeps the block busy on the next cycle
   `HKVT_ASSERT_NEXT(a_busy_after_req, req_beat, !req_ready)

   // a failed op never returns data
   `HKVT_ASSERT_NOW(a_miss_no_data, rsp_valid && !rsp_ok, rsp_data == '0)

   // a new response appears only as the sequencer returns to idle
   `HKVT_ASSERT_NOW(a_rsp_at_idle, $rose(rsp_valid), req_ready)

endmodule

bind hashed_key_value_table_core hkvt_checker u_hkvt_checker (.*);

### test/hashed_key_value_table_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hashed_key_value_table_core_tb
// Self-checking bench for the hashed key-value table core.
// ----------------------------------------------------------------------------
// A short table of probes covers the empty table, duplicate and missing keys,
// a full bucket, the extreme keys and values, and the spare op codes. Random
// traffic follows, mostly on a small pool of keys spread over a few buckets so
// that hits, chain fills and removals keep happening, with some fully random
// keys and spare ops mixed in. A behavioral copy of the table predicts each
// response except those of fixed probe rows; responses are checked in order.
module hashed_key_value_table_core_tb;
   import hkvt_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 11;
   localparam int IDLE_PCT     = 27;
   localparam int RANDOM_ITEMS = 1125;
   localparam int QUIET_FIRST  = 500;
   localparam int QUIET_LAST   = 700;
   localparam int TAIL_CYCLES  = 40;
   localparam int STALL_LIMIT  = 4000;
   localparam int POOL_BUCKETS = 8;
   localparam int POOL_PER_BKT = 6;
   localparam int POOL_SIZE    = POOL_BUCKETS * POOL_PER_BKT;

   // spare op codes, which the block must ignore
   localparam logic [OP_BITS-1:0] OP_SPARE5 = 3'd5;
   localparam logic [OP_BITS-1:0] OP_SPARE6 = 3'd6;
   localparam logic [OP_BITS-1:0] OP_SPARE7 = 3'd7;

   typedef struct packed {
      logic [OP_BITS-1:0]   op;
      logic [KEY_BITS-1:0]  key;
      logic [IN_BITS-1:0]   value;
      logic                 fixed;
      logic                 ok;
      logic [DATA_BITS-1:0] data;
   } probe_type;

   typedef struct packed {
      logic                 ok;
      logic [DATA_BITS-1:0] data;
   } lookup_rsp_type;

   // directed probes; fixed rows carry their expected response
   localparam int NUM_PROBES = 25;
   localparam probe_type PROBES [NUM_PROBES] = '{
      '{OP_GET,    32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
      '{OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
      '{OP_UPDATE, 32'h0000_0005, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
      '{OP_ADD,    32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000},
      '{OP_ADD,    32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
      '{OP_GET,    32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
      '{OP_ADD,    32'h0000_0040, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{OP_ADD,    32'h0000_0080, 32'h1357_9BDF, 1'b0, 1'b0, 32'h0000_0000},
      '{OP_ADD,    32'h0000_00C0, 32'h2468_ACE0, 1'b0, 1'b0, 32'h0000_0000},
      '{OP_ADD,    32'hFFFF_FFC0, 32'h1111_1111, 1'b1, 1'b0, 32'h0000_0000},
      '{OP_UPSERT, 32'hFFFF_FFC0, 32'h2222_2222, 1'b1, 1'b0, 32'h0000_0000},
      '{OP_UPSERT, 32'h0000_0040, 32'h1234_5678, 1'b0, 1'b0, 32'h0000_0000},
      '{OP_UPDATE, 32'h0000_0080, 32'hA5A5_A5A5, 1'b0, 1'b0, 32'h0000_0000},
      '{OP_GET,    32'h0000_0080, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{OP_REMOVE, 32'h0000_0040, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{OP_GET,    32'h0000_0040, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
      '{OP_UPSERT, 32'hFFFF_FFC0, 32'h5A5A_5A5A, 1'b0, 1'b0, 32'h0000_0000},
      '{OP_GET,    32'hFFFF_FFC0, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{OP_SPARE5, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
      '{OP_SPARE6, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
      '{OP_SPARE7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
      '{OP_ADD,    32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{OP_GET,    32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000}
   };

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [OP_BITS-1:0]   req_op    = OP_GET;
   logic [KEY_BITS-1:0]  req_key   = '0;
   logic [IN_BITS-1:0]   req_value = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_ok;
   logic [DATA_BITS-1:0] rsp_data;

   // expectation riding along with the beat on the bus
   logic                 beat_fixed = 1'b0;
   logic                 beat_ok    = 1'b0;
   logic [DATA_BITS-1:0] beat_data  = '0;

   logic                 quiet      = 1'b0;
   int                   fail_count = 0;
   int                   stall_cycles = 0;

   // shadow copy of the table
   logic                  shadow_valid [SLOTS];
   logic [KEY_BITS-1:0]   shadow_key   [SLOTS];
   logic [VALUE_BITS-1:0] shadow_value [SLOTS];

   lookup_rsp_type      pending_rsp [$];
   logic [KEY_BITS-1:0] key_pool [POOL_SIZE];

   hashed_key_value_table_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .req_key   (req_key),
      .req_value (req_value),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_ok    (rsp_ok),
      .rsp_data  (rsp_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
   endtask

   // apply one op to the shadow table and return the response it should give
   function automatic void apply_table_op(
      input  logic [OP_BITS-1:0]   op,
      input  logic [KEY_BITS-1:0]  key,
      input  logic [IN_BITS-1:0]   value,
      output logic                 ok,
      output logic [DATA_BITS-1:0] data
   );
      int                    base;
      int                    hit;
      int                    free;
      logic [VALUE_BITS-1:0] stored;
      base   = int'(key % BUCKETS) * WAYS;
      hit    = -1;
      free   = -1;
      stored = value;
      ok     = 1'b0;
      data   = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (hit < 0 && shadow_valid[base + w] && shadow_key[base + w] == key) hit = w;
         if (free < 0 && !shadow_valid[base + w]) free = w;
      end
      case (op)
         OP_ADD, OP_UPSERT: begin
            if (hit >= 0) begin
               if (op == OP_UPSERT) begin
                  shadow_value[base + hit] = stored;
                  ok = 1'b1;
               end
            end else if (free >= 0) begin
               shadow_valid[base + free] = 1'b1;
               shadow_key[base + free]   = key;
               shadow_value[base + free] = stored;
               ok = 1'b1;
            end
         end
         OP_UPDATE: begin
            if (hit >= 0) begin
               shadow_value[base + hit] = stored;
               ok = 1'b1;
            end
         end
         OP_GET, OP_REMOVE: begin
            if (hit >= 0) begin
               ok   = 1'b1;
               data = shadow_value[base + hit];
               if (op == OP_REMOVE) shadow_valid[base + hit] = 1'b0;
            end
         end
         default: ;
      endcase
   endfunction

   // present one request beat and hold it until it is taken
   task automatic send_request(
      input logic [OP_BITS-1:0]   op,
      input logic [KEY_BITS-1:0]  key,
      input logic [IN_BITS-1:0]   value,
      input logic                 fixed,
      input logic                 ok,
      input logic [DATA_BITS-1:0] data
   );
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_op     <= op;
      req_key    <= key;
      req_value  <= value;
      beat_fixed <= fixed;
      beat_ok    <= ok;
      beat_data  <= data;
      do @(posedge clock); while (!req_ready);
   endtask

   // response side backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // predict on each request beat, check each response beat, watch for hangs
   always @(posedge clock) begin : monitor
      logic                 ok_p;
      logic [DATA_BITS-1:0] data_p;
      lookup_rsp_type       head;
      if (!reset) begin
         if (req_valid && req_ready) begin
            apply_table_op(req_op, req_key, req_value, ok_p, data_p);
            if (beat_fixed) begin
               ok_p   = beat_ok;
               data_p = beat_data;
            end
            pending_rsp.push_back('{ok: ok_p, data: data_p});
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               report_mismatch($sformatf("unexpected response ok=%0b data=%h",
                                         rsp_ok, rsp_data));
            end else begin
               head = pending_rsp.pop_front();
               if (rsp_ok !== head.ok)
                  report_mismatch($sformatf("ok %0b, want %0b", rsp_ok, head.ok));
               if (rsp_data !== head.data)
                  report_mismatch($sformatf("data %h, want %h", rsp_data, head.data));
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin : stimulus
      int                   counted;
      int                   bkt;
      int                   roll;
      logic [OP_BITS-1:0]   op;
      logic [KEY_BITS-1:0]  key;
      logic [IN_BITS-1:0]   value;
      for (int i = 0; i < SLOTS; i++) shadow_valid[i] = 1'b0;

      // keys crowded into a few buckets, so chains fill up and hits are common
      for (int b = 0; b < POOL_BUCKETS; b++) begin
         if (b == 0)      bkt = 0;
         else if (b == 1) bkt = BUCKETS - 1;
         else             bkt = $urandom_range(BUCKETS - 1);
         for (int k = 0; k < POOL_PER_BKT; k++) begin
            key = $urandom();
            key_pool[b * POOL_PER_BKT + k] = key - (key % BUCKETS) + bkt;
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed probes
      for (int i = 0; i < NUM_PROBES; i++) begin
         send_request(PROBES[i].op, PROBES[i].key, PROBES[i].value,
                      PROBES[i].fixed, PROBES[i].ok, PROBES[i].data);
      end

      // random traffic, spare ops included
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         quiet <= (counted >= QUIET_FIRST && counted < QUIET_LAST);
         roll = $urandom_range(99);
         if (roll < 22)      op = OP_ADD;
         else if (roll < 34) op = OP_UPDATE;
         else if (roll < 56) op = OP_UPSERT;
         else if (roll < 76) op = OP_GET;
         else if (roll < 94) op = OP_REMOVE;
         else begin
            case ($urandom_range(2))
               0:       op = OP_SPARE5;
               1:       op = OP_SPARE6;
               default: op = OP_SPARE7;
            endcase
         end
         if ($urandom_range(99) < 85) key = key_pool[$urandom_range(POOL_SIZE - 1)];
         else                         key = $urandom();
         case ($urandom_range(15))
            0:       value = '0;
            1:       value = '1;
            default: value = $urandom();
         endcase
         send_request(op, key, value, 1'b0, 1'b0, '0);
         counted++;
      end
      req_valid <= 1'b0;
      quiet     <= 1'b0;

      // drain, then give stray responses a chance to show up
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
